>>> rtl/core/pbc_pkg.sv
// Shared types, constants and helpers for the playout buffer controller.
// Used by the top level and by its port checker; depends on nothing.
package pbc_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SUM_W           = 34;

  localparam logic        POLICY_RESET = 1'b0;
  localparam logic [4:0]  FILL_RESET   = 5'd2;
  localparam logic [31:0] LATE_RESET   = 32'd33333;
  localparam logic [16:0] ALPHA_RESET  = 17'd62259;
  localparam logic [4:0]  TARGET_RESET = 5'd0;
  localparam logic [31:0] AVG_RESET    = 32'd8000;
  localparam logic [31:0] STEP_RESET   = 32'd2500;
  localparam logic [16:0] Q16_ONE      = 17'h10000;
  localparam logic signed [SUM_W-1:0] SLEEP_GAIN = 34'sd15;

  typedef enum logic [1:0] {
    MODE_ARRIVAL = 2'd0,
    MODE_POLL    = 2'd1,
    MODE_ADJUST  = 2'd2
  } mode_t;

  localparam logic [1:0] SLOPE_POS = 2'd1;
  localparam logic [1:0] SLOPE_NEG = 2'd2;

  typedef enum logic [2:0] {
    REG_POLICY = 3'd0,
    REG_FILL   = 3'd1,
    REG_LATE   = 3'd2,
    REG_ALPHA  = 3'd3,
    REG_TARGET = 3'd4
  } reg_idx_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'sh7FFFFFFF);
    lo = -(SUM_W'(32'sh7FFFFFFF)) - SUM_W'(1);
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

>>> rtl/core/playout_buffer_controller.sv
// Playout buffer controller: frame count, arrival gap average, release and sleep offset.
// Depends on pbc_pkg for constants, mode codes and the saturation helper.
// Results are registered, in the output entry or, while it stalls, the second entry.
// Throughput: one request per cycle; a two-entry output stage keeps accepting
// while one result waits, and in_ready drops only when both entries are full.
// Reset: synchronous, active low; clears registers, state and both output entries.
module playout_buffer_controller
  import pbc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [31:0]         in_arrival_time_us,
  input  logic                in_key_frame,
  input  logic [1:0]          in_slope_sign,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_released,
  output logic                out_dropped,
  output logic                out_overflow,
  output logic [CNT_W-1:0]    out_queue_count,
  output logic                out_draining,
  output logic [31:0]         out_avg_frame_time_us,
  output logic signed [31:0]  out_sleep_offset,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int DW   = (CNT_W > 5) ? CNT_W : 5;
  localparam int DD_W = 2 * DW;

  typedef struct packed {
    logic               released;
    logic               dropped;
    logic               overflow;
    logic [CNT_W-1:0]   queue_count;
    logic               draining;
    logic [31:0]        avg;
    logic signed [31:0] sleep_offset;
  } res_t;

  logic               policy_r;
  logic [4:0]         fill_limit_r;
  logic [31:0]        late_limit_r;
  logic [16:0]        alpha_r;
  logic [4:0]         target_r;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               drain_r, drain_nxt;
  logic [31:0]        avg_r, avg_nxt;
  logic [31:0]        last_r, last_nxt;
  logic               seen_r, seen_nxt;
  logic signed [31:0] offset_r, offset_nxt;
  logic signed [31:0] step_r, step_nxt;

  res_t               res;
  res_t               out_r, skid_r;
  logic               out_valid_r, skid_valid_r;
  logic               accept;
  logic               cfg_wr;

  logic [16:0]               alpha_c;
  logic [16:0]               weight;
  logic [31:0]               gap;
  logic signed [32:0]        diff;
  logic signed [50:0]        prod;
  logic [DW-1:0]             cnt_ext, tg_ext, occ_dist;
  logic [DD_W-1:0]           dd;
  logic signed [SUM_W-1:0]   dd_s, gain_s;
  logic signed [31:0]        step_new;
  logic                      late, go;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_POLICY: prdata = {31'd0, policy_r};
      REG_FILL:   prdata = {27'd0, fill_limit_r};
      REG_LATE:   prdata = late_limit_r;
      REG_ALPHA:  prdata = {15'd0, alpha_r};
      REG_TARGET: prdata = {27'd0, target_r};
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    alpha_c  = (alpha_r > Q16_ONE) ? Q16_ONE : alpha_r;
    weight   = Q16_ONE - alpha_c;
    gap      = in_arrival_time_us - last_r;
    diff     = $signed({1'b0, gap}) - $signed({1'b0, avg_r});
    prod     = diff * $signed({1'b0, weight});
    cnt_ext  = DW'(count_r);
    tg_ext   = DW'(target_r);
    occ_dist = (cnt_ext > tg_ext) ? (cnt_ext - tg_ext) : (tg_ext - cnt_ext);
    dd       = DD_W'(occ_dist) * DD_W'(occ_dist);
    dd_s     = SUM_W'(dd);
    gain_s   = dd_s * SLEEP_GAIN;
    late     = policy_r && (gap > late_limit_r) && !in_key_frame;
    go       = 1'b0;
    step_new = step_r;

    count_nxt  = count_r;
    drain_nxt  = drain_r;
    avg_nxt    = avg_r;
    last_nxt   = last_r;
    seen_nxt   = seen_r;
    offset_nxt = offset_r;
    step_nxt   = step_r;
    res        = '0;

    unique case (mode_t'(in_mode))
      MODE_ARRIVAL: begin
        if (!policy_r || seen_r) begin
          avg_nxt = avg_r + prod[47:16];
        end
        if (late) begin
          res.dropped = 1'b1;
        end else if (32'(count_r) >= 32'(QUEUE_DEPTH)) begin
          res.dropped  = 1'b1;
          res.overflow = 1'b1;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
        last_nxt = in_arrival_time_us;
        seen_nxt = 1'b1;
      end
      MODE_POLL: begin
        if (policy_r) begin
          if (!drain_r) begin
            go = cnt_ext >= DW'(fill_limit_r);
            if (go) begin
              drain_nxt = 1'b1;
            end
          end else begin
            go = count_r != '0;
            if (!go) begin
              drain_nxt = 1'b0;
            end
          end
        end else begin
          go = count_r != '0;
        end
        if (go && count_r != '0) begin
          count_nxt    = count_r - CNT_W'(1);
          res.released = 1'b1;
        end
      end
      MODE_ADJUST: begin
        if (cnt_ext > tg_ext) begin
          if (in_slope_sign != SLOPE_NEG) begin
            step_new = sat32(SUM_W'(step_r) + gain_s);
          end
          step_nxt   = step_new;
          offset_nxt = sat32(SUM_W'(offset_r) + SUM_W'(step_new));
        end else if (cnt_ext < tg_ext) begin
          if (in_slope_sign == SLOPE_POS) begin
            offset_nxt = sat32(SUM_W'(offset_r) - dd_s);
          end else begin
            offset_nxt = sat32(SUM_W'(offset_r) - gain_s);
          end
        end
      end
      default: begin
      end
    endcase

    res.queue_count  = count_nxt;
    res.draining     = drain_nxt;
    res.avg          = avg_nxt;
    res.sleep_offset = offset_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= POLICY_RESET;
      fill_limit_r <= FILL_RESET;
      late_limit_r <= LATE_RESET;
      alpha_r      <= ALPHA_RESET;
      target_r     <= TARGET_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_POLICY: policy_r     <= pwdata[0];
        REG_FILL:   fill_limit_r <= pwdata[4:0];
        REG_LATE:   late_limit_r <= pwdata;
        REG_ALPHA:  alpha_r      <= pwdata[16:0];
        REG_TARGET: target_r     <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      drain_r  <= 1'b0;
      avg_r    <= AVG_RESET;
      last_r   <= '0;
      seen_r   <= 1'b0;
      offset_r <= '0;
      step_r   <= STEP_RESET;
    end else if (accept) begin
      count_r  <= count_nxt;
      drain_r  <= drain_nxt;
      avg_r    <= avg_nxt;
      last_r   <= last_nxt;
      seen_r   <= seen_nxt;
      offset_r <= offset_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
        if (accept) begin
          out_r <= res;
        end
      end
    end else if (accept) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_released          = out_r.released;
  assign out_dropped           = out_r.dropped;
  assign out_overflow          = out_r.overflow;
  assign out_queue_count       = out_r.queue_count;
  assign out_draining          = out_r.draining;
  assign out_avg_frame_time_us = out_r.avg;
  assign out_sleep_offset      = out_r.sleep_offset;

endmodule

>>> rtl/core/pbc_checker.sv
// Port-level checker for the playout buffer controller, bound to the top level.
// Depends on pbc_pkg for the default queue depth.
module pbc_checker
  import pbc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_released,
  input logic                out_dropped,
  input logic                out_overflow,
  input logic [CNT_W-1:0]    out_queue_count
);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_queue_count) <= 32'(QUEUE_DEPTH))
    else $error("Reported queue count exceeds the queue depth.");

  a_overflow_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_dropped)
    else $error("Overflow reported without a drop.");

  a_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_released |-> !out_dropped)
    else $error("A result reports both a release and a drop.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_queue_count))
    else $error("Stalled result changed or vanished.");

endmodule

bind playout_buffer_controller pbc_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_pbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_released    (out_released),
  .out_dropped     (out_dropped),
  .out_overflow    (out_overflow),
  .out_queue_count (out_queue_count)
);

>>> bench/pbc_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the playout buffer controller: predicts every request and compares results.
// Depends on pbc_pkg for mode codes, register indexes and reset constants.
module pbc_result_checker
  import pbc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [31:0]        in_arrival_time_us,
  input  logic               in_key_frame,
  input  logic [1:0]         in_slope_sign,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_released,
  input  logic               out_dropped,
  input  logic               out_overflow,
  input  logic [4:0]         out_queue_count,
  input  logic               out_draining,
  input  logic [31:0]        out_avg_frame_time_us,
  input  logic signed [31:0] out_sleep_offset,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 backlog
);

  typedef struct packed {
    logic               released;
    logic               dropped;
    logic               overflow;
    logic [4:0]         count;
    logic               draining;
    logic [31:0]        avg;
    logic signed [31:0] sleep;
  } outcome_t;

  outcome_t pending_outcomes[$];

  logic        cfg_policy;
  logic [4:0]  cfg_fill;
  logic [31:0] cfg_late;
  logic [16:0] cfg_alpha;
  logic [4:0]  cfg_target;

  int          held;
  logic        drain_st;
  logic [31:0] avg_gap;
  logic [31:0] prev_arrival;
  logic        got_first;
  longint      offset_acc;
  longint      offset_inc;

  function automatic longint clamp_s32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic predict_outcome(input logic [1:0] mode, input logic [31:0] t_arr,
                                 input logic key, input logic [1:0] slope,
                                 output outcome_t r);
    logic [31:0] gap;
    logic [16:0] wt;
    logic [63:0] acc;
    logic        late;
    logic        go;
    longint      d;
    longint      dd;
    r = '0;
    case (mode)
      MODE_ARRIVAL: begin
        gap = t_arr - prev_arrival;
        if (!cfg_policy || got_first) begin
          wt = (cfg_alpha > Q16_ONE) ? Q16_ONE : cfg_alpha;
          acc = 64'(avg_gap) * 64'(wt) + 64'(Q16_ONE - wt) * 64'(gap);
          avg_gap = acc[47:16];
        end
        late = cfg_policy && (gap > cfg_late) && !key;
        if (late) begin
          r.dropped = 1'b1;
        end else if (held >= DEPTH) begin
          r.dropped = 1'b1;
          r.overflow = 1'b1;
        end else begin
          held++;
        end
        prev_arrival = t_arr;
        got_first = 1'b1;
      end
      MODE_POLL: begin
        if (cfg_policy) begin
          if (!drain_st) begin
            go = held >= int'(cfg_fill);
            if (go) drain_st = 1'b1;
          end else begin
            go = held != 0;
            if (!go) drain_st = 1'b0;
          end
        end else begin
          go = held != 0;
        end
        if (go && held != 0) begin
          held--;
          r.released = 1'b1;
        end
      end
      MODE_ADJUST: begin
        d = (held > int'(cfg_target)) ? longint'(held) - longint'(cfg_target)
                                      : longint'(cfg_target) - longint'(held);
        dd = d * d;
        if (held > int'(cfg_target)) begin
          if (slope != SLOPE_NEG) offset_inc = clamp_s32(offset_inc + dd * SLEEP_GAIN);
          offset_acc = clamp_s32(offset_acc + offset_inc);
        end else if (held < int'(cfg_target)) begin
          if (slope == SLOPE_POS) begin
            offset_acc = clamp_s32(offset_acc - dd);
          end else begin
            offset_acc = clamp_s32(offset_acc - dd * SLEEP_GAIN);
          end
        end
      end
      default: begin
      end
    endcase
    r.count = held[4:0];
    r.draining = drain_st;
    r.avg = avg_gap;
    r.sleep = offset_acc[31:0];
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    outcome_t fresh;
    if (!rst_n) begin
      cfg_policy = POLICY_RESET;
      cfg_fill = FILL_RESET;
      cfg_late = LATE_RESET;
      cfg_alpha = ALPHA_RESET;
      cfg_target = TARGET_RESET;
      held = 0;
      drain_st = 1'b0;
      avg_gap = AVG_RESET;
      prev_arrival = '0;
      got_first = 1'b0;
      offset_acc = 0;
      offset_inc = longint'(STEP_RESET);
      pending_outcomes.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_POLICY: cfg_policy = pwdata[0];
          REG_FILL:   cfg_fill = pwdata[4:0];
          REG_LATE:   cfg_late = pwdata;
          REG_ALPHA:  cfg_alpha = pwdata[16:0];
          REG_TARGET: cfg_target = pwdata[4:0];
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          compare_field("released", want.released, out_released);
          compare_field("dropped", want.dropped, out_dropped);
          compare_field("overflow", want.overflow, out_overflow);
          compare_field("queue_count", want.count, out_queue_count);
          compare_field("draining", want.draining, out_draining);
          compare_field("avg_frame_time_us", want.avg, out_avg_frame_time_us);
          compare_field("sleep_offset", longint'(want.sleep), longint'(out_sleep_offset));
        end
      end
      if (in_valid && in_ready) begin
        predict_outcome(in_mode, in_arrival_time_us, in_key_frame, in_slope_sign, fresh);
        pending_outcomes.insert(pending_outcomes.size(), fresh);
      end
    end
    backlog <= pending_outcomes.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the playout buffer controller testbench: clock, reset, stimulus and verdict.
// Depends on pbc_pkg, the playout_buffer_controller block and pbc_result_checker.
module tb_top;
  import pbc_pkg::*;

  localparam int         CYCLE_LIMIT = 200000;
  localparam logic [1:0] MODE_UNDEF  = 2'd3;
  localparam logic [1:0] SLOPE_ZERO  = 2'd0;
  localparam logic [1:0] SLOPE_UNDEF = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode = '0;
  logic [31:0]        in_arrival_time_us = '0;
  logic               in_key_frame = 1'b0;
  logic [1:0]         in_slope_sign = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic               out_released;
  logic               out_dropped;
  logic               out_overflow;
  logic [4:0]         out_queue_count;
  logic               out_draining;
  logic [31:0]        out_avg_frame_time_us;
  logic signed [31:0] out_sleep_offset;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int          mismatches;
  int          backlog;
  int          cycles = 0;
  int          ready_hold = 0;
  int          stall_draw;
  bit          calm = 1'b1;
  logic [31:0] arr_clock = '0;

  always #6 clk = ~clk;

  playout_buffer_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_arrival_time_us(in_arrival_time_us), .in_key_frame(in_key_frame),
    .in_slope_sign(in_slope_sign),
    .out_valid(out_valid), .out_ready(out_ready), .out_released(out_released),
    .out_dropped(out_dropped), .out_overflow(out_overflow),
    .out_queue_count(out_queue_count), .out_draining(out_draining),
    .out_avg_frame_time_us(out_avg_frame_time_us), .out_sleep_offset(out_sleep_offset),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pbc_result_checker u_result_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_arrival_time_us(in_arrival_time_us), .in_key_frame(in_key_frame),
    .in_slope_sign(in_slope_sign),
    .out_valid(out_valid), .out_ready(out_ready), .out_released(out_released),
    .out_dropped(out_dropped), .out_overflow(out_overflow),
    .out_queue_count(out_queue_count), .out_draining(out_draining),
    .out_avg_frame_time_us(out_avg_frame_time_us), .out_sleep_offset(out_sleep_offset),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .backlog(backlog)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("playout_buffer_controller: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
      ready_hold <= 0;
    end else if (out_ready && out_valid) begin
      stall_draw = calm ? 0 : $urandom_range(0, 3);
      if (stall_draw != 0) out_ready <= 1'b0;
      ready_hold <= stall_draw;
    end else if (!out_ready) begin
      if (ready_hold <= 1) out_ready <= 1'b1;
      ready_hold <= ready_hold - 1;
    end
  end

  task automatic push_request(input logic [1:0] m, input logic [31:0] t, input logic key,
                              input logic [1:0] slope);
    int idle;
    idle = calm ? 0 : $urandom_range(0, 3);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_arrival_time_us <= t;
    in_key_frame <= key;
    in_slope_sign <= slope;
    if (m == MODE_ARRIVAL) arr_clock = t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input logic pol, input logic [4:0] fill, input logic [31:0] late,
                           input logic [16:0] alpha, input logic [4:0] target);
    settle();
    write_reg(REG_POLICY, 32'(pol));
    write_reg(REG_FILL, 32'(fill));
    write_reg(REG_LATE, late);
    write_reg(REG_ALPHA, 32'(alpha));
    write_reg(REG_TARGET, 32'(target));
  endtask

  task automatic run_phase(input logic pol, input logic [4:0] fill, input logic [31:0] late,
                           input logic [16:0] alpha, input logic [4:0] target, input int n);
    int          tilt;
    int          pick;
    longint      span;
    logic [1:0]  m;
    logic [31:0] t;
    configure(pol, fill, late, alpha, target);
    span = (late > 100000) ? 100000 : longint'(late);
    tilt = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        tilt = $urandom_range(0, 2);
        calm = ($urandom_range(0, 4) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        m = MODE_UNDEF;
      end else if (pick < 18) begin
        m = MODE_ADJUST;
      end else if (pick < (tilt == 0 ? 70 : (tilt == 1 ? 40 : 58))) begin
        m = MODE_ARRIVAL;
      end else begin
        m = MODE_POLL;
      end
      case ($urandom_range(0, 9))
        0: t = $urandom();
        1, 2: t = arr_clock + late + 32'($urandom_range(0, 2)) - 32'd1;
        3, 4, 5: t = arr_clock + 32'($urandom_range(0, 100));
        default: t = arr_clock + 32'($urandom_range(0, 32'(2 * span)));
      endcase
      push_request(m, t, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hysteresis from reset: the first frame leaves the average alone.
    write_reg(REG_POLICY, 32'd1);
    push_request(MODE_ARRIVAL, 32'd40000, 1'b0, SLOPE_ZERO);
    push_request(MODE_ARRIVAL, 32'd40010, 1'b0, SLOPE_ZERO);
    push_request(MODE_POLL, 32'd0, 1'b0, SLOPE_ZERO);
    push_request(MODE_ARRIVAL, 32'd40020, 1'b1, SLOPE_ZERO);
    push_request(MODE_POLL, 32'd0, 1'b0, SLOPE_ZERO);
    push_request(MODE_POLL, 32'd0, 1'b0, SLOPE_ZERO);
    push_request(MODE_POLL, 32'd0, 1'b0, SLOPE_ZERO);

    configure(1'b0, FILL_RESET, LATE_RESET, ALPHA_RESET, TARGET_RESET);
    push_request(MODE_POLL, 32'd0, 1'b0, SLOPE_ZERO);
    push_request(MODE_ADJUST, 32'd0, 1'b0, SLOPE_ZERO);
    push_request(MODE_ARRIVAL, 32'hFFFF_FFFF, 1'b1, SLOPE_ZERO);
    push_request(MODE_ARRIVAL, 32'd5, 1'b0, SLOPE_ZERO);
    push_request(MODE_UNDEF, 32'hFFFF_FFFF, 1'b1, SLOPE_UNDEF);
    push_request(MODE_ADJUST, 32'd0, 1'b0, SLOPE_ZERO);
    push_request(MODE_ADJUST, 32'd0, 1'b0, SLOPE_NEG);
    push_request(MODE_ADJUST, 32'd0, 1'b0, SLOPE_UNDEF);
    push_request(MODE_POLL, 32'd0, 1'b0, SLOPE_ZERO);
    push_request(MODE_POLL, 32'd0, 1'b0, SLOPE_ZERO);

    // Fill limit zero turns to draining on an empty queue without a release.
    configure(1'b1, 5'd0, 32'd0, 17'h1FFFF, 5'd31);
    push_request(MODE_POLL, 32'd0, 1'b0, SLOPE_ZERO);
    push_request(MODE_POLL, 32'd0, 1'b0, SLOPE_ZERO);
    push_request(MODE_ARRIVAL, 32'd100, 1'b0, SLOPE_ZERO);
    push_request(MODE_ARRIVAL, 32'd200, 1'b1, SLOPE_ZERO);
    push_request(MODE_ARRIVAL, 32'd200, 1'b0, SLOPE_ZERO);
    push_request(MODE_ADJUST, 32'd0, 1'b0, SLOPE_POS);
    push_request(MODE_ADJUST, 32'd0, 1'b0, SLOPE_ZERO);

    run_phase(1'b0, 5'd2, 32'd33333, 17'd62259, 5'd0, 40);
    run_phase(1'b1, 5'd16, 32'd33333, 17'd0, 5'd16, 40);
    run_phase(1'b1, 5'd1, 32'hFFFF_FFFF, 17'h10000, 5'd5, 40);
    run_phase(1'b0, 5'd31, 32'd0, 17'h1FFFF, 5'd31, 40);
    run_phase(1'b1, 5'($urandom_range(0, 31)), 32'($urandom_range(1, 100000)),
              17'($urandom_range(0, 131071)), 5'($urandom_range(0, 31)), 40);
    run_phase(1'b1, 5'd8, 32'd1000, 17'd32768, 5'd8, 40);

    // Hold the queue full above the target until the sleep offset saturates.
    configure(1'b0, 5'd2, 32'd33333, 17'd62259, 5'd0);
    calm = 1'b1;
    for (int k = 0; k < 20; k++) begin
      push_request(MODE_ARRIVAL, arr_clock + 32'd16000, 1'b1, SLOPE_ZERO);
    end
    calm = 1'b0;
    for (int k = 0; k < 1150; k++) begin
      push_request(MODE_ADJUST, $urandom(), 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 19) == 0) ? SLOPE_NEG : 2'($urandom_range(0, 1)));
    end
    configure(1'b0, 5'd2, 32'd33333, 17'd62259, 5'd31);
    for (int k = 0; k < 40; k++) begin
      push_request(($urandom_range(0, 1) == 0) ? MODE_POLL : MODE_ADJUST, $urandom(),
                   1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("playout_buffer_controller: match");
    end else begin
      $display("playout_buffer_controller: mismatch");
    end
    $finish;
  end

endmodule
